// File: rtl/sfr_pkg.sv
package sfr_pkg;

    // Configuration port geometry
    localparam int CFG_DW    = 64;
    localparam int CFG_IW    = 3;
    localparam int LEN_W     = 5;
    localparam int CFG_BYTES = 16;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Line break byte: flushes the window
    localparam logic [7:0] NEWLINE = 8'h0A;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_PAT_LO  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PAT_HI  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_PAT_LEN = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_REP_LO  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_REP_HI  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_REP_LEN = 3'd5;

    // Live configuration; lengths are already clamped to the usable range
    typedef struct packed {
        logic [CFG_BYTES-1:0][7:0] pat;
        logic [LEN_W-1:0]          plen;
        logic [CFG_BYTES-1:0][7:0] rep;
        logic [LEN_W-1:0]          rlen;
    } t_cfg;

endpackage

// File: rtl/stream_find_replace.sv
// Channel   Dir  Beat                      Fields (lowest bit up)
// s_axis    in   one text byte             tdata: in_byte; tlast: stream_end
// m_axis    out  one result               tdata: out_byte; tuser: has_byte,
//                                           stream_done; tlast: run_last
// i_cfg_*   in   one register write        index, 64-bit data
//
// An input byte is classified in the cycle it is accepted; a byte that releases
// one result keeps a rate of one beat per cycle while m_axis_tready is high. A
// byte that releases N results (flush or replacement, N up to 16) sends N beats;
// the job queue (4 entries) absorbs that and then holds s_axis_tready low.
// Reset is synchronous, active low; it empties the window and the queue and
// loads the register reset values. No clearing pass is needed.
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // in_byte
    input  logic              s_axis_tlast,   // stream_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // out_byte
    output logic [1:0]        m_axis_tuser,   // has_byte, stream_done
    output logic              m_axis_tlast    // run_last
);

    localparam int NSLOT = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int QW    = NSLOT * 8 + CW + 1;

    t_cfg             r_cfg;
    logic             w_clr;
    logic [LEN_W-1:0] w_len_in;

    logic                  f_push;
    logic [NSLOT-1:0][7:0] f_bytes;
    logic [CW-1:0]         f_cnt;
    logic                  f_end;
    logic                  q_room;
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_data;

    assign w_len_in = i_cfg_data[LEN_W-1:0];

    // Empty the window at the edge that writes the pattern length
    assign w_clr = i_cfg_wen && (i_cfg_idx == CFG_PAT_LEN);

    // Register writes; lengths are clamped on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat  <= '0;
            r_cfg.plen <= LEN_W'(1);
            r_cfg.rep  <= '0;
            r_cfg.rlen <= '0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    CFG_PAT_LO:  r_cfg.pat[7:0]  <= i_cfg_data;
                    CFG_PAT_HI:  r_cfg.pat[15:8] <= i_cfg_data;
                    CFG_PAT_LEN: begin
                        if (w_len_in == '0) begin
                            r_cfg.plen <= LEN_W'(1);
                        end else if (w_len_in > LEN_W'(MAX_PATTERN)) begin
                            r_cfg.plen <= LEN_W'(MAX_PATTERN);
                        end else begin
                            r_cfg.plen <= w_len_in;
                        end
                    end
                    CFG_REP_LO:  r_cfg.rep[7:0]  <= i_cfg_data;
                    CFG_REP_HI:  r_cfg.rep[15:8] <= i_cfg_data;
                    CFG_REP_LEN: begin
                        if (w_len_in > LEN_W'(MAX_REPLACEMENT)) begin
                            r_cfg.rlen <= LEN_W'(MAX_REPLACEMENT);
                        end else begin
                            r_cfg.rlen <= w_len_in;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .NSLOT       (NSLOT),
        .CW          (CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clr       (w_clr),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_room      (q_room),
        .o_push      (f_push),
        .o_job_bytes (f_bytes),
        .o_job_cnt   (f_cnt),
        .o_job_end   (f_end)
    );

    sfr_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_end, f_cnt, f_bytes}),
        .o_room  (q_room),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    sfr_back #(
        .NSLOT (NSLOT),
        .CW    (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job_bytes (q_data[NSLOT*8-1:0]),
        .i_job_cnt   (q_data[NSLOT*8 +: CW]),
        .i_job_end   (q_data[QW-1]),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_has       (m_axis_tuser[0]),
        .o_last      (m_axis_tlast),
        .o_done      (m_axis_tuser[1])
    );

    // A byte-less result closes its run and carries a zero byte
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("byte-less result not closing its run");

    // End of stream is only flagged on the closing result of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("stream_done without run_last");

    // The back end never releases a job that is not there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job queue popped while empty");

    // The front end only pushes when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> q_room && s_axis_tvalid)
        else $error("job queue pushed while full");

endmodule

// File: rtl/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int NSLOT       = 16,
    parameter int CW          = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_clr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    input  logic                  i_room,
    output logic                  o_push,
    output logic [NSLOT-1:0][7:0] o_job_bytes,
    output logic [CW-1:0]         o_job_cnt,
    output logic                  o_job_end
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0][7:0] r_win, n_win;
    logic [LW-1:0]               r_cnt, n_cnt;

    logic [MAX_PATTERN-1:0][7:0] w_push;
    logic [MAX_PATTERN-1:0][7:0] w_shift;
    logic [NSLOT-1:0][7:0]       w_job;
    logic [LW-1:0]               w_cnt1;
    logic [LW-1:0]               w_plen;
    logic                        w_nl;
    logic                        w_full;
    logic                        w_match;
    logic                        w_hit;
    logic                        w_acc;

    assign o_ready = i_room;
    assign w_acc   = i_valid && i_room;
    assign o_push  = w_acc;

    assign w_plen = i_cfg.plen[LW-1:0];
    assign w_cnt1 = r_cnt + LW'(1);
    assign w_nl   = (i_byte == NEWLINE);
    assign w_full = (w_cnt1 == w_plen);

    // Append the new byte behind the pending ones and compare the pattern
    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_push[i] = (LW'(i) == r_cnt) ? i_byte : r_win[i];
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LW'(i) < w_plen) && (w_push[i] != i_cfg.pat[i])) begin
                w_match = 1'b0;
            end
        end
        w_shift = w_push;
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            w_shift[i] = w_push[i+1];
        end
    end

    assign w_hit = !w_nl && w_full && w_match;

    // Job bytes: the window in order, or the replacement on a hit
    for (genvar g = 0; g < NSLOT; g++) begin : g_job
        if (g < MAX_PATTERN) begin : g_win
            assign w_job[g] = w_push[g];
        end else begin : g_pad
            assign w_job[g] = '0;
        end
        assign o_job_bytes[g] = w_hit ? i_cfg.rep[g] : w_job[g];
    end

    // Number of bytes this beat releases
    always_comb begin
        if (w_hit) begin
            o_job_cnt = CW'(i_cfg.rlen);
        end else if (w_nl || i_end) begin
            o_job_cnt = CW'(w_cnt1);
        end else if (w_full) begin
            o_job_cnt = CW'(1);
        end else begin
            o_job_cnt = '0;
        end
    end
    assign o_job_end = i_end;

    // Next window: empty on flush, hit or clear; on a miss drop the oldest if full, else append
    always_comb begin
        n_win = r_win;
        n_cnt = r_cnt;
        if (w_acc) begin
            if (w_nl || i_end || w_hit) begin
                n_cnt = '0;
            end else if (w_full) begin
                n_win = w_shift;
                n_cnt = w_plen - LW'(1);
            end else begin
                n_win = w_push;
                n_cnt = w_cnt1;
            end
        end
        if (i_clr) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// File: rtl/sfr_queue.sv
module sfr_queue #(
    parameter int W     = 134,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_room,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][W-1:0] r_mem;
    logic [AW-1:0]           r_wr, n_wr;
    logic [AW-1:0]           r_rd, n_rd;
    logic [NW-1:0]           r_num, n_num;

    assign o_room  = (r_num != NW'(DEPTH));
    assign o_valid = (r_num != '0);
    assign o_data  = r_mem[r_rd];

    // Advance pointers and fill level
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_num = r_num;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_num = r_num + NW'(1);
        end else if (!i_push && i_pop) begin
            n_num = r_num - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_num <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/sfr_back.sv
module sfr_back #(
    parameter int NSLOT = 16,
    parameter int CW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [NSLOT-1:0][7:0] i_job_bytes,
    input  logic [CW-1:0]         i_job_cnt,
    input  logic                  i_job_end,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_has,
    output logic                  o_last,
    output logic                  o_done
);

    localparam int IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    logic [IW-1:0] r_idx, n_idx;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_has;
    logic          r_last;
    logic          r_done;

    logic          w_load;
    logic          w_has;
    logic          w_last;
    logic [7:0]    w_byte;

    // Build the next beat from the head job
    assign w_has  = (i_job_cnt != '0);
    assign w_last = !w_has || ((CW'(r_idx) + CW'(1)) == i_job_cnt);
    assign w_byte = w_has ? i_job_bytes[r_idx] : 8'h00;
    assign w_load = i_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_last;

    // Step through the job, release it after its last beat
    always_comb begin
        n_idx = r_idx;
        if (w_load) begin
            n_idx = w_last ? '0 : r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_has  <= w_has;
            r_last <= w_last;
            r_done <= w_last && i_job_end;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_has   = r_has;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule
